// ===== hdl/cyrillic_codepage_to_unicode_decoder_assert.svh =====
// assertion macros shared by the decoder rtl
// no dependencies; included by files that carry concurrent checks
`ifndef CYRILLIC_CODEPAGE_TO_UNICODE_DECODER_ASSERT_SVH
`define CYRILLIC_CODEPAGE_TO_UNICODE_DECODER_ASSERT_SVH

// condition must hold on every edge out of reset
`define CPD_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("cpd check failed");

// consequence must hold in the cycle after the antecedent
`define CPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpd check failed");

`endif

// ===== hdl/cpd_pkg.sv =====
// types, mode codes and the code page mapping for the cyrillic decoder
// no dependencies
`default_nettype none

package cpd_pkg;

    typedef logic [10:0] t_cp;
    typedef t_cp t_rom [512];

    localparam logic [2:0] MODE_NONE   = 3'd0;
    localparam logic [2:0] MODE_CP866  = 3'd1;
    localparam logic [2:0] MODE_CP1251 = 3'd2;
    localparam logic [2:0] MODE_KOI8R  = 3'd3;
    localparam logic [2:0] MODE_UTF8   = 3'd4;

    localparam logic [2:0] MODE_RESET  = MODE_UTF8;

    // koi8-r lower case letters for 0xc0..0xdf
    localparam t_cp KOI_LOWER [32] = '{
        11'h44E, 11'h430, 11'h431, 11'h446, 11'h434, 11'h435, 11'h444, 11'h433,
        11'h445, 11'h438, 11'h439, 11'h43A, 11'h43B, 11'h43C, 11'h43D, 11'h43E,
        11'h43F, 11'h44F, 11'h440, 11'h441, 11'h442, 11'h443, 11'h436, 11'h432,
        11'h44C, 11'h44B, 11'h437, 11'h448, 11'h44D, 11'h449, 11'h447, 11'h44A
    };

    typedef struct packed {
        logic emit;
        t_cp  cp;
    } t_utf_res;

    typedef struct packed {
        logic       await_second;
        logic [4:0] lead_payload;
        logic [2:0] bytes_to_skip;
    } t_utf_state;

    // high byte (bit 7 implied set) under a code page row
    function automatic t_cp map_high(input logic [1:0] row, input logic [6:0] b7);
        t_cp r;
        r = '0;
        case (row)
            MODE_CP866[1:0]: begin
                if (b7 <= 7'h1F) r = 11'h410 + {4'd0, b7};
                else if (b7 >= 7'h20 && b7 <= 7'h2F) r = 11'h430 + {4'd0, b7 - 7'h20};
                else if (b7 >= 7'h60 && b7 <= 7'h6F) r = 11'h440 + {4'd0, b7 - 7'h60};
                else if (b7 == 7'h70) r = 11'h401;
                else if (b7 == 7'h71) r = 11'h451;
            end
            MODE_CP1251[1:0]: begin
                if (b7 == 7'h28) r = 11'h401;
                else if (b7 == 7'h38) r = 11'h451;
                else if (b7 >= 7'h40) r = 11'h410 + {4'd0, b7 - 7'h40};
            end
            MODE_KOI8R[1:0]: begin
                if (b7 == 7'h23) r = 11'h451;
                else if (b7 == 7'h33) r = 11'h401;
                else if (b7 >= 7'h40 && b7 <= 7'h5F) r = KOI_LOWER[b7[4:0]];
                else if (b7 >= 7'h60) r = KOI_LOWER[b7[4:0]] - 11'h020;
            end
            default: r = '0;
        endcase
        return r;
    endfunction

    // rom image indexed by {row, low seven bits of the byte}
    function automatic t_rom build_rom();
        t_rom m;
        for (int i = 0; i < 512; i++) begin
            m[i] = map_high(2'(i >> 7), 7'(i));
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/cpd_if.sv =====
// stream interfaces for the byte input and the code point output
// no dependencies
`default_nettype none

interface cpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface cpd_cp_if;
    logic        valid;
    logic        ready;
    logic [10:0] code_point;

    modport source (output valid, output code_point, input ready);
    modport sink   (input valid, input code_point, output ready);
endinterface

`default_nettype wire

// ===== hdl/cpd_utf8_track.sv =====
// utf-8 sequence tracker: pending lead and skip count, result per byte
// depends on cpd_pkg
`default_nettype none

module cpd_utf8_track (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_step,
    input  wire                 i_clear,
    input  wire  [7:0]          i_byte,
    output cpd_pkg::t_utf_res   o_res,
    output cpd_pkg::t_utf_state o_state
);
    import cpd_pkg::*;

    t_utf_state r_st;
    t_utf_state n_st;

    always_comb begin
        n_st  = r_st;
        o_res = '0;
        if (r_st.bytes_to_skip != 3'd0) begin
            n_st.bytes_to_skip = r_st.bytes_to_skip - 3'd1;
        end else if (r_st.await_second) begin
            o_res.emit = 1'b1;
            o_res.cp   = {r_st.lead_payload, i_byte[5:0]};
            n_st       = '0;
        end else if (!i_byte[7]) begin
            o_res.emit = 1'b1;
            o_res.cp   = {4'd0, i_byte[6:0]};
        end else if (i_byte[7:5] == 3'b110) begin
            n_st.await_second = 1'b1;
            n_st.lead_payload = i_byte[4:0];
        end else if (i_byte[7:4] == 4'b1110) begin
            n_st.bytes_to_skip = 3'd2;
        end else if (i_byte[7:3] == 5'b11110) begin
            n_st.bytes_to_skip = 3'd3;
        end else if (i_byte[7:2] == 6'b111110) begin
            n_st.bytes_to_skip = 3'd4;
        end else if (i_byte[7:1] == 7'b1111110) begin
            n_st.bytes_to_skip = 3'd5;
        end
        // stray continuation bytes and 0xfe/0xff fall through and are dropped
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_st <= '0;
        end else if (i_step) begin
            r_st <= n_st;
        end
    end

    assign o_state = r_st;

endmodule

`default_nettype wire

// ===== hdl/cyrillic_codepage_to_unicode_decoder.sv =====
// path: an input byte is registered in stage 1 and then in the output register
// throughput: one byte per cycle unless the output stalls; the mapping rom is read once per
//   byte and the utf-8 tracker updates its state in the cycle the byte is taken
// bytes that give no code point (utf-8 leads and skipped trail bytes) leave no output
// reset: synchronous, active low; clears the pipeline, the utf-8 state and sets utf8 mode
// depends on cpd_pkg, cpd_if, cpd_utf8_track and the assertion macro header
`default_nettype none
`include "cyrillic_codepage_to_unicode_decoder_assert.svh"

module cyrillic_codepage_to_unicode_decoder (
    input  wire         i_clk,
    input  wire         i_rst_n,
    cpd_byte_if.sink    i_in,
    cpd_cp_if.source    o_out,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import cpd_pkg::*;

    localparam t_rom MAP_ROM = build_rom();

    typedef enum logic {
        SRC_DIRECT,
        SRC_ROM
    } t_src;

    logic [2:0] r_mode;
    logic       cfg_wr;
    logic       in_xfer;
    logic       is_utf8;
    logic       is_page;
    logic       s1_go;
    logic       out_load;

    t_utf_res   utf_res;
    t_utf_state utf_st;

    logic r_s1_v;
    logic r_s1_emit;
    t_src r_s1_src;
    t_cp  r_s1_cp;
    t_cp  r_rom_q;
    logic r_out_v;
    t_cp  r_out_cp;

    // register file: one mode register at indices 0..3 (paddr bit 2 clear)
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {29'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
        end else if (cfg_wr) begin
            r_mode <= pwdata[2:0];
        end
    end

    assign is_utf8 = (r_mode == MODE_UTF8);
    assign is_page = (r_mode == MODE_CP866) || (r_mode == MODE_CP1251) ||
                     (r_mode == MODE_KOI8R);

    // stage 1 moves on when empty, holding nothing to send, or the output can take it
    assign s1_go    = !r_s1_v || !r_s1_emit || !r_out_v || o_out.ready;
    assign out_load = r_s1_v && r_s1_emit && (!r_out_v || o_out.ready);
    assign i_in.ready = s1_go;
    assign in_xfer    = i_in.valid && s1_go;

    cpd_utf8_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (in_xfer && is_utf8),
        .i_clear (cfg_wr),
        .i_byte  (i_in.in_byte),
        .o_res   (utf_res),
        .o_state (utf_st)
    );

    // synchronous rom read, held while stage 1 is stalled
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_rom_q <= MAP_ROM[{r_mode[1:0], i_in.in_byte[6:0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s1_emit <= 1'b0;
            r_s1_src  <= SRC_DIRECT;
            r_out_v   <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_s1_v <= 1'b1;
                if (is_utf8) begin
                    r_s1_emit <= utf_res.emit;
                    r_s1_src  <= SRC_DIRECT;
                    r_s1_cp   <= utf_res.cp;
                end else begin
                    r_s1_emit <= 1'b1;
                    r_s1_src  <= (is_page && i_in.in_byte[7]) ? SRC_ROM : SRC_DIRECT;
                    // unsupported modes give zero for high bytes
                    r_s1_cp   <= i_in.in_byte[7] ? 11'd0 : {3'd0, i_in.in_byte};
                end
            end else if (s1_go) begin
                r_s1_v <= 1'b0;
            end

            if (out_load) begin
                r_out_v  <= 1'b1;
                r_out_cp <= (r_s1_src == SRC_ROM) ? r_rom_q : r_s1_cp;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_out.valid      = r_out_v;
    assign o_out.code_point = r_out_cp;

    `CPD_ASSERT_ALWAYS(a_skip_range, i_clk, i_rst_n, utf_st.bytes_to_skip <= 3'd5)
    `CPD_ASSERT_ALWAYS(a_pending_excl, i_clk, i_rst_n,
        !(utf_st.await_second && (utf_st.bytes_to_skip != 3'd0)))
    `CPD_ASSERT_NEXT(a_cfg_clears, i_clk, i_rst_n, cfg_wr,
        !utf_st.await_second && (utf_st.bytes_to_skip == 3'd0))
    `CPD_ASSERT_NEXT(a_page_emits, i_clk, i_rst_n, in_xfer && !is_utf8,
        r_s1_v && r_s1_emit)
    `CPD_ASSERT_NEXT(a_stall_holds_s1, i_clk, i_rst_n, r_s1_v && r_s1_emit && !s1_go,
        r_s1_v && r_s1_emit && $stable(r_s1_cp) && $stable(r_rom_q))

endmodule

`default_nettype wire
